@@ design/brf_pkg.sv @@
`default_nettype none
package brf_pkg;

  localparam int LEN_W      = 7;
  localparam int FREE_W     = 9;
  localparam int ADDR_MAX_W = 16;
  localparam int QDEPTH     = 4;

  typedef enum logic [2:0] {
    FN_PUSH   = 3'd0,
    FN_FETCH  = 3'd1,
    FN_PEEK   = 3'd2,
    FN_REWIND = 3'd3,
    FN_CLEAR  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_STAT  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_kind_t;

  // one classified transaction, handed from front to back
  typedef struct packed {
    cmd_kind_t               kind;
    logic [ADDR_MAX_W-1:0]   addr;
    logic [7:0]              data;
    logic [LEN_W-1:0]        count;
    status_t                 status;
    logic [FREE_W-1:0]       free_rd;
    logic [FREE_W-1:0]       free_pk;
  } cmd_t;

endpackage
`default_nettype wire

@@ design/brf_front.sv @@
`default_nettype none
module brf_front
  import brf_pkg::*;
#(
  parameter int DEPTH     = 256,
  parameter int MAX_BURST = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [2:0]       in_func,
  input  wire logic [7:0]       in_data_in,
  input  wire logic [LEN_W-1:0] in_req_len,
  input  wire logic             q_full,
  output logic                  q_push,
  output cmd_t                  q_data
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [LEN_W-1:0] BURST_MAX = LEN_W'(MAX_BURST);

  logic             in_v_r;
  logic [2:0]       func_r;
  logic [7:0]       data_r;
  logic [LEN_W-1:0] len_r;

  logic [AW-1:0] wr_addr_r, wr_addr_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [AW-1:0] pk_addr_r, pk_addr_nxt;
  // bytes between write pointer and read / peek pointer, mod 2^32
  logic [31:0]   used_rd_r, used_rd_nxt;
  logic [31:0]   used_pk_r, used_pk_nxt;

  logic [31:0]      avail;
  logic [LEN_W-1:0] len_cl;
  logic [LEN_W-1:0] grant;
  logic             take;
  cmd_t             cmd;

  function automatic logic [FREE_W-1:0] free_of(input logic [31:0] used);
    if (used >= 32'(DEPTH)) return '0;
    return FREE_W'(32'(DEPTH) - used);
  endfunction

  assign take   = in_v_r && !q_full;
  assign busy   = in_v_r && q_full;
  assign q_push = take;
  assign q_data = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (start && !busy) begin
      in_v_r <= 1'b1;
    end else if (take) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      func_r <= in_func;
      data_r <= in_data_in;
      len_r  <= in_req_len;
    end
  end

  always_comb begin
    avail  = (func_r == FN_FETCH) ? used_rd_r : used_pk_r;
    len_cl = (len_r > BURST_MAX) ? BURST_MAX : len_r;
    grant  = (avail < 32'(len_cl)) ? avail[LEN_W-1:0] : len_cl;

    wr_addr_nxt = wr_addr_r;
    rd_addr_nxt = rd_addr_r;
    pk_addr_nxt = pk_addr_r;
    used_rd_nxt = used_rd_r;
    used_pk_nxt = used_pk_r;

    cmd        = '0;
    cmd.kind   = CMD_STAT;
    cmd.status = ST_OK;

    unique case (func_r)
      FN_PUSH: begin
        if (used_rd_r < 32'(DEPTH)) begin
          cmd.kind    = CMD_WRITE;
          cmd.addr    = ADDR_MAX_W'(wr_addr_r);
          cmd.data    = data_r;
          wr_addr_nxt = wr_addr_r + AW'(1);
          used_rd_nxt = used_rd_r + 32'd1;
          used_pk_nxt = used_pk_r + 32'd1;
        end else begin
          cmd.status = ST_FULL;
        end
      end
      FN_FETCH: begin
        if (grant == '0) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.kind    = CMD_READ;
          cmd.addr    = ADDR_MAX_W'(rd_addr_r);
          cmd.count   = grant;
          rd_addr_nxt = rd_addr_r + AW'(grant);
          used_rd_nxt = used_rd_r - 32'(grant);
        end
      end
      FN_PEEK: begin
        if (grant == '0) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.kind    = CMD_READ;
          cmd.addr    = ADDR_MAX_W'(pk_addr_r);
          cmd.count   = grant;
          pk_addr_nxt = pk_addr_r + AW'(grant);
          used_pk_nxt = used_pk_r - 32'(grant);
        end
      end
      FN_REWIND: begin
        pk_addr_nxt = rd_addr_r;
        used_pk_nxt = used_rd_r;
      end
      FN_CLEAR: begin
        wr_addr_nxt = '0;
        rd_addr_nxt = '0;
        pk_addr_nxt = '0;
        used_rd_nxt = '0;
        used_pk_nxt = '0;
      end
      default: begin
      end
    endcase

    cmd.free_rd = free_of(used_rd_nxt);
    cmd.free_pk = free_of(used_pk_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_addr_r <= '0;
      rd_addr_r <= '0;
      pk_addr_r <= '0;
      used_rd_r <= '0;
      used_pk_r <= '0;
    end else if (take) begin
      wr_addr_r <= wr_addr_nxt;
      rd_addr_r <= rd_addr_nxt;
      pk_addr_r <= pk_addr_nxt;
      used_rd_r <= used_rd_nxt;
      used_pk_r <= used_pk_nxt;
    end
  end

  // read side can never hold more than the ring
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_rd_r <= 32'(DEPTH))
    else $error("read occupancy above depth");

endmodule
`default_nettype wire

@@ design/brf_queue.sv @@
`default_nettype none
module brf_queue
  import brf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          slot_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop)  rp_r <= rp_r + PW'(1);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule
`default_nettype wire

@@ design/brf_back.sv @@
`default_nettype none
module brf_back
  import brf_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              q_head,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  output logic [7:0]             out_data_out,
  output logic                   out_last,
  output logic [1:0]             out_status,
  output logic [FREE_W-1:0]      out_free_after_fetch,
  output logic [FREE_W-1:0]      out_free_after_peek
);

  localparam int AW = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];

  logic             cur_v_r;
  cmd_t             cur_r;
  logic [AW-1:0]    addr_r;
  logic [LEN_W-1:0] cnt_r;
  logic             done;
  logic             is_rd;
  logic             is_wr;

  logic              ov_r;
  logic              last_r;
  logic              sel_r;
  logic [7:0]        rdata_r;
  status_t           status_r;
  logic [FREE_W-1:0] free_rd_r;
  logic [FREE_W-1:0] free_pk_r;

  assign is_rd = cur_v_r && (cur_r.kind == CMD_READ);
  assign is_wr = cur_v_r && (cur_r.kind == CMD_WRITE);
  // no transaction is current, or the current one issues its final beat this cycle
  assign done  = !cur_v_r || (cur_r.kind != CMD_READ) || (cnt_r == LEN_W'(1));
  assign q_pop = done && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
    end else if (done) begin
      cur_v_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r  <= q_head;
      addr_r <= q_head.addr[AW-1:0];
      cnt_r  <= q_head.count;
    end else if (!done) begin
      addr_r <= addr_r + AW'(1);
      cnt_r  <= cnt_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (is_wr) begin
      mem[addr_r] <= cur_r.data;
    end
  end

  always_ff @(posedge clk) begin
    if (is_rd) begin
      rdata_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= cur_v_r;
    end
  end

  always_ff @(posedge clk) begin
    sel_r     <= is_rd;
    last_r    <= !is_rd || (cnt_r == LEN_W'(1));
    status_r  <= cur_r.status;
    free_rd_r <= cur_r.free_rd;
    free_pk_r <= cur_r.free_pk;
  end

  assign out_valid            = ov_r;
  assign out_data_out         = sel_r ? rdata_r : 8'd0;
  assign out_last             = last_r;
  assign out_status           = status_r;
  assign out_free_after_fetch = free_rd_r;
  assign out_free_after_peek  = free_pk_r;

  a_burst_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    is_rd |-> cnt_r != '0)
    else $error("read burst with zero count");

  // a burst is delivered without gaps
  a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside read burst");

endmodule
`default_nettype wire

@@ design/byte_ring_fifo_with_peek.sv @@
// Channel   Ports                                        Handshake
// input     in_func, in_data_in, in_req_len              start & !busy
// result    out_data_out, out_last, out_status,          out_valid, one cycle each
//           out_free_after_fetch, out_free_after_peek
//
// Push, rewind, clear and status-only transactions each yield one result.
// A fetch or peek of n granted bytes yields n results (one memory read
// port, one byte per cycle); the first result passes through the input register,
// the command queue, the current-transaction register and the output registers.
// Reset (synchronous, rst_n low) zeroes all pointers; store contents persist.
// busy rises while the input register holds an item and the command queue
// is full; results are never held back.
`default_nettype none
module byte_ring_fifo_with_peek
  import brf_pkg::*;
#(
  parameter int DEPTH     = 256,
  parameter int MAX_BURST = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_func,
  input  wire logic [7:0]        in_data_in,
  input  wire logic [LEN_W-1:0]  in_req_len,
  output logic                   out_valid,
  output logic [7:0]             out_data_out,
  output logic                   out_last,
  output logic [1:0]             out_status,
  output logic [FREE_W-1:0]      out_free_after_fetch,
  output logic [FREE_W-1:0]      out_free_after_peek
);

  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_wdata, q_head;

  brf_front #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_func    (in_func),
    .in_data_in (in_data_in),
    .in_req_len (in_req_len),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  brf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  brf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_head               (q_head),
    .q_empty              (q_empty),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_data_out         (out_data_out),
    .out_last             (out_last),
    .out_status           (out_status),
    .out_free_after_fetch (out_free_after_fetch),
    .out_free_after_peek  (out_free_after_peek)
  );

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import brf_pkg::*;

  localparam int RING_DEPTH = 256;
  localparam int BURST_MAX  = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 12;
  localparam int MAX_REPORTS = 10;

  // func codes the block leaves unused
  localparam logic [2:0] FN_RSVD5 = 3'd5;
  localparam logic [2:0] FN_RSVD6 = 3'd6;
  localparam logic [2:0] FN_RSVD7 = 3'd7;

  typedef struct {
    logic [7:0]        data;
    logic              last;
    status_t           status;
    logic [FREE_W-1:0] free_rd;
    logic [FREE_W-1:0] free_pk;
  } ring_result_t;

  typedef struct {
    logic [2:0]        func;
    logic [7:0]        data;
    logic [LEN_W-1:0]  len;
    bit                typed;
    logic [7:0]        e_data;
    status_t           e_status;
    logic [FREE_W-1:0] e_free_rd;
    logic [FREE_W-1:0] e_free_pk;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        in_func = '0;
  logic [7:0]        in_data_in = '0;
  logic [LEN_W-1:0]  in_req_len = '0;
  logic              out_valid;
  logic [7:0]        out_data_out;
  logic              out_last;
  logic [1:0]        out_status;
  logic [FREE_W-1:0] out_free_after_fetch;
  logic [FREE_W-1:0] out_free_after_peek;

  // shadow copy of the ring
  logic [7:0]  ring_bytes [RING_DEPTH];
  bit          ring_written [RING_DEPTH];
  logic [31:0] wr_ptr = '0;
  logic [31:0] rd_ptr = '0;
  logic [31:0] pk_ptr = '0;

  ring_result_t pending_results [$];
  int           mismatches = 0;
  int           quiet_cycles = 0;
  bit           no_gaps = 1'b0;
  dir_row_t     dir_tbl [22];

  always #6 clk = ~clk;

  byte_ring_fifo_with_peek #(
    .DEPTH     (RING_DEPTH),
    .MAX_BURST (BURST_MAX)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_func              (in_func),
    .in_data_in           (in_data_in),
    .in_req_len           (in_req_len),
    .out_valid            (out_valid),
    .out_data_out         (out_data_out),
    .out_last             (out_last),
    .out_status           (out_status),
    .out_free_after_fetch (out_free_after_fetch),
    .out_free_after_peek  (out_free_after_peek)
  );

  function automatic logic [FREE_W-1:0] free_from(logic [31:0] ptr);
    logic [31:0] used;
    used = wr_ptr - ptr;
    if (used >= RING_DEPTH) return '0;
    return FREE_W'(RING_DEPTH - used);
  endfunction

  // shortens a read so it never touches a ring entry that was never written
  function automatic logic [LEN_W-1:0] readable_len(logic [2:0] fn, logic [LEN_W-1:0] len);
    logic [31:0] base;
    logic [31:0] avail;
    int          k;
    base  = (fn == FN_FETCH) ? rd_ptr : pk_ptr;
    avail = wr_ptr - base;
    k = 0;
    while (k < len && k < avail && k < BURST_MAX &&
           ring_written[(base + k) & (RING_DEPTH - 1)])
      k++;
    if (k < len && k < avail && k < BURST_MAX) return LEN_W'(k);
    return len;
  endfunction

  // applies one accepted transaction and queues the results it yields
  task automatic ring_step(input logic [2:0] fn, input logic [7:0] din,
                           input logic [LEN_W-1:0] len);
    logic [31:0]  base;
    logic [31:0]  avail;
    int           n;
    status_t      st;
    logic [7:0]   got [BURST_MAX];
    ring_result_t r;
    n  = 0;
    st = ST_OK;
    case (fn)
      FN_PUSH: begin
        if (wr_ptr - rd_ptr < RING_DEPTH) begin
          ring_bytes[wr_ptr & (RING_DEPTH - 1)]   = din;
          ring_written[wr_ptr & (RING_DEPTH - 1)] = 1'b1;
          wr_ptr = wr_ptr + 1;
        end else begin
          st = ST_FULL;
        end
      end
      FN_FETCH, FN_PEEK: begin
        base  = (fn == FN_FETCH) ? rd_ptr : pk_ptr;
        avail = wr_ptr - base;
        n = len;
        if (n > avail) n = avail;
        if (n > BURST_MAX) n = BURST_MAX;
        if (n == 0) st = ST_EMPTY;
        for (int i = 0; i < n; i++) got[i] = ring_bytes[(base + i) & (RING_DEPTH - 1)];
        if (fn == FN_FETCH) rd_ptr = base + n;
        else pk_ptr = base + n;
      end
      FN_REWIND: pk_ptr = rd_ptr;
      FN_CLEAR: begin
        wr_ptr = '0;
        rd_ptr = '0;
        pk_ptr = '0;
      end
      default: ;
    endcase
    r.free_rd = free_from(rd_ptr);
    r.free_pk = free_from(pk_ptr);
    r.status  = st;
    if (n == 0) begin
      r.data = '0;
      r.last = 1'b1;
      pending_results.push_back(r);
    end else begin
      for (int i = 0; i < n; i++) begin
        r.data = got[i];
        r.last = (i == n - 1);
        pending_results.push_back(r);
      end
    end
  endtask

  // drives one transaction after an idle gap and predicts it once accepted
  task automatic issue(input logic [2:0] fn, input logic [7:0] din,
                       input logic [LEN_W-1:0] len, input int gap,
                       input bit typed, input ring_result_t typed_res);
    logic [LEN_W-1:0] len_ok;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    len_ok = (fn == FN_FETCH || fn == FN_PEEK) ? readable_len(fn, len) : len;
    start      <= 1'b1;
    in_func    <= fn;
    in_data_in <= din;
    in_req_len <= len_ok;
    @(posedge clk);
    while (busy) @(posedge clk);
    ring_step(fn, din, len_ok);
    if (typed) pending_results[pending_results.size() - 1] = typed_res;
  endtask

  function automatic int draw_gap(int idx);
    if (idx % 24 == 0) no_gaps = ($urandom_range(0, 2) == 0);
    return no_gaps ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [LEN_W-1:0] draw_len();
    if ($urandom_range(0, 5) == 0) return LEN_W'(BURST_MAX);
    return LEN_W'($urandom_range(0, BURST_MAX));
  endfunction

  // result checker
  always @(posedge clk) begin
    ring_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: data %02h last %0d status %0d free %0d/%0d",
                   out_data_out, out_last, out_status,
                   out_free_after_fetch, out_free_after_peek);
      end else begin
        want = pending_results.pop_front();
        if (out_data_out !== want.data || out_last !== want.last ||
            out_status !== want.status || out_free_after_fetch !== want.free_rd ||
            out_free_after_peek !== want.free_pk) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: exp data %02h last %0d status %0d free %0d/%0d",
                     want.data, want.last, want.status, want.free_rd, want.free_pk);
            $display("          got data %02h last %0d status %0d free %0d/%0d",
                     out_data_out, out_last, out_status,
                     out_free_after_fetch, out_free_after_peek);
          end
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    ring_result_t tr;
    int           idx;
    int           pick;
    logic [2:0]   fn;

    dir_tbl = '{
      '{FN_FETCH,  8'h00, 7'd5,  1'b1, 8'h00, ST_EMPTY, 9'd256, 9'd256},
      '{FN_PEEK,   8'hFF, 7'd64, 1'b1, 8'h00, ST_EMPTY, 9'd256, 9'd256},
      '{FN_PUSH,   8'h00, 7'd0,  1'b1, 8'h00, ST_OK,    9'd255, 9'd255},
      '{FN_PUSH,   8'hFF, 7'd64, 1'b1, 8'h00, ST_OK,    9'd254, 9'd254},
      '{FN_PUSH,   8'hA5, 7'd3,  1'b1, 8'h00, ST_OK,    9'd253, 9'd253},
      '{FN_PUSH,   8'h5A, 7'd1,  1'b1, 8'h00, ST_OK,    9'd252, 9'd252},
      '{FN_PEEK,   8'h00, 7'd0,  1'b1, 8'h00, ST_EMPTY, 9'd252, 9'd252},
      '{FN_PEEK,   8'h00, 7'd2,  1'b0, 8'h00, ST_OK,    9'd0,   9'd0},
      '{FN_FETCH,  8'h00, 7'd1,  1'b0, 8'h00, ST_OK,    9'd0,   9'd0},
      '{FN_REWIND, 8'h00, 7'd0,  1'b1, 8'h00, ST_OK,    9'd253, 9'd253},
      '{FN_PEEK,   8'h00, 7'd64, 1'b0, 8'h00, ST_OK,    9'd0,   9'd0},
      '{FN_FETCH,  8'h00, 7'd64, 1'b0, 8'h00, ST_OK,    9'd0,   9'd0},
      '{FN_FETCH,  8'h00, 7'd3,  1'b1, 8'h00, ST_EMPTY, 9'd256, 9'd256},
      '{FN_RSVD5,  8'hAA, 7'd64, 1'b1, 8'h00, ST_OK,    9'd256, 9'd256},
      '{FN_RSVD6,  8'h55, 7'd0,  1'b1, 8'h00, ST_OK,    9'd256, 9'd256},
      '{FN_RSVD7,  8'hFF, 7'd64, 1'b1, 8'h00, ST_OK,    9'd256, 9'd256},
      '{FN_PUSH,   8'h3C, 7'd0,  1'b1, 8'h00, ST_OK,    9'd255, 9'd255},
      '{FN_CLEAR,  8'h00, 7'd0,  1'b1, 8'h00, ST_OK,    9'd256, 9'd256},
      '{FN_PUSH,   8'h81, 7'd0,  1'b1, 8'h00, ST_OK,    9'd255, 9'd255},
      '{FN_PEEK,   8'h00, 7'd1,  1'b0, 8'h00, ST_OK,    9'd0,   9'd0},
      '{FN_REWIND, 8'h00, 7'd0,  1'b1, 8'h00, ST_OK,    9'd255, 9'd255},
      '{FN_FETCH,  8'h00, 7'd64, 1'b0, 8'h00, ST_OK,    9'd0,   9'd0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idx = 0;
    foreach (dir_tbl[i]) begin
      tr.data    = dir_tbl[i].e_data;
      tr.last    = 1'b1;
      tr.status  = dir_tbl[i].e_status;
      tr.free_rd = dir_tbl[i].e_free_rd;
      tr.free_pk = dir_tbl[i].e_free_pk;
      issue(dir_tbl[i].func, dir_tbl[i].data, dir_tbl[i].len, draw_gap(idx++),
            dir_tbl[i].typed, tr);
    end

    // fill past full, drain part of it, then push on so the peek pointer lags
    for (int i = 0; i < 262; i++)
      issue(FN_PUSH, 8'($urandom), draw_len(), draw_gap(idx++), 1'b0, tr);
    for (int i = 0; i < 3; i++)
      issue(FN_FETCH, 8'($urandom), LEN_W'($urandom_range(40, BURST_MAX)),
            draw_gap(idx++), 1'b0, tr);
    for (int i = 0; i < 20; i++)
      issue(FN_PUSH, 8'($urandom), draw_len(), draw_gap(idx++), 1'b0, tr);

    for (int i = 0; i < 45; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 42)      fn = FN_PUSH;
      else if (pick < 60) fn = FN_FETCH;
      else if (pick < 82) fn = FN_PEEK;
      else if (pick < 90) fn = FN_REWIND;
      else if (pick < 93) fn = FN_CLEAR;
      else if (pick < 95) fn = FN_RSVD5;
      else if (pick < 97) fn = FN_RSVD6;
      else                fn = FN_RSVD7;
      issue(fn, 8'($urandom), draw_len(), draw_gap(idx++), 1'b0, tr);
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
